FILE: src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and helper functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

    // Eight 32-bit words: chaining values or working variables
    typedef logic [7:0][31:0] t_words;

    // Input mode codes
    localparam logic [1:0] MODE_APPEND      = 2'd0;
    localparam logic [1:0] MODE_APPEND_LAST = 2'd1;
    localparam logic [1:0] MODE_FINISH      = 2'd2;

    // Padding marker byte and the block offset where the length field starts
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;

    // Initial hash values, word 0 in slice 0
    localparam t_words SHA_IV = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    // Control from the byte sequencer to the compression unit
    typedef struct packed {
        logic        word_we;   // shift one message word into the window
        logic [31:0] word;
        logic        start;     // begin the 64 rounds on the current window
        logic        init_h;    // return chaining words to the initial values
    } t_core_ctl;

    // Status back from the compression unit
    typedef struct packed {
        logic busy;
        logic done;             // high in the cycle the chaining words update
    } t_core_sts;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // Round constants
    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        case (idx)
            6'd0:  sha_k = 32'h428A2F98;  6'd1:  sha_k = 32'h71374491;
            6'd2:  sha_k = 32'hB5C0FBCF;  6'd3:  sha_k = 32'hE9B5DBA5;
            6'd4:  sha_k = 32'h3956C25B;  6'd5:  sha_k = 32'h59F111F1;
            6'd6:  sha_k = 32'h923F82A4;  6'd7:  sha_k = 32'hAB1C5ED5;
            6'd8:  sha_k = 32'hD807AA98;  6'd9:  sha_k = 32'h12835B01;
            6'd10: sha_k = 32'h243185BE;  6'd11: sha_k = 32'h550C7DC3;
            6'd12: sha_k = 32'h72BE5D74;  6'd13: sha_k = 32'h80DEB1FE;
            6'd14: sha_k = 32'h9BDC06A7;  6'd15: sha_k = 32'hC19BF174;
            6'd16: sha_k = 32'hE49B69C1;  6'd17: sha_k = 32'hEFBE4786;
            6'd18: sha_k = 32'h0FC19DC6;  6'd19: sha_k = 32'h240CA1CC;
            6'd20: sha_k = 32'h2DE92C6F;  6'd21: sha_k = 32'h4A7484AA;
            6'd22: sha_k = 32'h5CB0A9DC;  6'd23: sha_k = 32'h76F988DA;
            6'd24: sha_k = 32'h983E5152;  6'd25: sha_k = 32'hA831C66D;
            6'd26: sha_k = 32'hB00327C8;  6'd27: sha_k = 32'hBF597FC7;
            6'd28: sha_k = 32'hC6E00BF3;  6'd29: sha_k = 32'hD5A79147;
            6'd30: sha_k = 32'h06CA6351;  6'd31: sha_k = 32'h14292967;
            6'd32: sha_k = 32'h27B70A85;  6'd33: sha_k = 32'h2E1B2138;
            6'd34: sha_k = 32'h4D2C6DFC;  6'd35: sha_k = 32'h53380D13;
            6'd36: sha_k = 32'h650A7354;  6'd37: sha_k = 32'h766A0ABB;
            6'd38: sha_k = 32'h81C2C92E;  6'd39: sha_k = 32'h92722C85;
            6'd40: sha_k = 32'hA2BFE8A1;  6'd41: sha_k = 32'hA81A664B;
            6'd42: sha_k = 32'hC24B8B70;  6'd43: sha_k = 32'hC76C51A3;
            6'd44: sha_k = 32'hD192E819;  6'd45: sha_k = 32'hD6990624;
            6'd46: sha_k = 32'hF40E3585;  6'd47: sha_k = 32'h106AA070;
            6'd48: sha_k = 32'h19A4C116;  6'd49: sha_k = 32'h1E376C08;
            6'd50: sha_k = 32'h2748774C;  6'd51: sha_k = 32'h34B0BCB5;
            6'd52: sha_k = 32'h391C0CB3;  6'd53: sha_k = 32'h4ED8AA4A;
            6'd54: sha_k = 32'h5B9CCA4F;  6'd55: sha_k = 32'h682E6FF3;
            6'd56: sha_k = 32'h748F82EE;  6'd57: sha_k = 32'h78A5636F;
            6'd58: sha_k = 32'h84C87814;  6'd59: sha_k = 32'h8CC70208;
            6'd60: sha_k = 32'h90BEFFFA;  6'd61: sha_k = 32'hA4506CEB;
            6'd62: sha_k = 32'hBEF9A3F7;  6'd63: sha_k = 32'hC67178F2;
            default: sha_k = 32'h0;
        endcase
    endfunction

endpackage

FILE: src/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// Byte-wide SHA-256 hasher: collects message bytes, pads on finish and
// streams out the eight digest words.
// ----------------------------------------------------------------------------
// Usage:
// Input channel (i_valid / o_stall): one item carries i_mode and
// i_message_byte. Mode 0 appends the byte, mode 1 appends it and finishes,
// mode 2 finishes without a byte; mode 3 is taken and ignored.
// A plain byte is taken while the hasher is idle. Every 64th byte starts a
// compression that holds o_stall high through the 64 rounds of the shared round
// unit plus one chaining update. A finish pads one byte per cycle up to the
// end of the block, compresses (twice when more than 55 bytes were pending),
// then offers eight digest words on the output channel (o_valid / i_stall),
// word 0 first, with o_last_word on word 7. Input stays stalled until the
// last word is taken; a stalled output word holds. After the last word the
// hasher is back at its initial state. Reset (i_rst_n low, synchronous) clears
// the pending block and the byte count and loads the initial hash values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_message_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sha_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_HASH, S_PAD, S_OUT} t_state;

    t_state      r_state;
    logic [5:0]  r_fill;       // bytes pending in the block
    logic [60:0] r_total;      // message bytes, wraps at 2^61
    logic [23:0] r_acc;        // partial big-endian word
    logic        r_pad_first;  // next pad byte is the marker
    logic        r_len_ok;     // this block carries the length field
    logic        r_pad_pend;   // padding continues after the compression
    logic        r_last;       // the compression running is the final one
    logic        r_out_valid;
    logic [2:0]  r_widx;

    logic          in_take, out_take;
    logic          wr_en;
    logic [7:0]    wr_byte;
    logic [7:0][7:0] len_bytes;
    t_core_ctl     core_ctl;
    t_core_sts     core_sts;
    t_words        core_h;

    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;
    assign o_stall  = (r_state != S_IDLE);

    // Message length in bits, big-endian byte 0 in slice 7
    assign len_bytes = {r_total, 3'b000};

    // Byte into the block: a message byte or a pad byte
    always_comb begin
        wr_en   = 1'b0;
        wr_byte = i_message_byte;
        case (r_state)
            S_IDLE: begin
                wr_en = in_take && (i_mode == MODE_APPEND || i_mode == MODE_APPEND_LAST);
            end
            S_PAD: begin
                wr_en = 1'b1;
                if (r_pad_first) begin
                    wr_byte = PAD_MARKER;
                end else if (r_len_ok && r_fill >= LEN_OFFSET) begin
                    wr_byte = len_bytes[3'd7 - r_fill[2:0]];
                end else begin
                    wr_byte = 8'h00;
                end
            end
            default: wr_en = 1'b0;
        endcase
    end

    // Control to the compression unit
    always_comb begin
        core_ctl.word_we = wr_en && (r_fill[1:0] == 2'd3);
        core_ctl.word    = {r_acc, wr_byte};
        core_ctl.start   = wr_en && (r_fill == 6'd63);
        core_ctl.init_h  = out_take && (r_widx == 3'd7);
    end

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .o_sts   (core_sts),
        .o_h     (core_h)
    );

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= 6'd0;
            r_total     <= 61'd0;
            r_pad_first <= 1'b0;
            r_len_ok    <= 1'b0;
            r_pad_pend  <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
            r_widx      <= 3'd0;
        end else begin
            if (wr_en) begin
                r_fill <= r_fill + 6'd1;
                r_acc  <= {r_acc[15:0], wr_byte};
            end
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        case (i_mode)
                            MODE_APPEND, MODE_APPEND_LAST: begin
                                r_total     <= r_total + 61'd1;
                                r_pad_first <= 1'b1;
                                if (r_fill == 6'd63) begin
                                    r_state    <= S_HASH;
                                    r_last     <= 1'b0;
                                    r_pad_pend <= (i_mode == MODE_APPEND_LAST);
                                end else if (i_mode == MODE_APPEND_LAST) begin
                                    r_state <= S_PAD;
                                end
                            end
                            MODE_FINISH: begin
                                r_pad_first <= 1'b1;
                                r_state     <= S_PAD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (r_pad_first) begin
                        r_len_ok <= (r_fill < LEN_OFFSET);
                    end
                    if (r_fill == 6'd63) begin
                        r_state    <= S_HASH;
                        r_pad_pend <= 1'b1;
                        r_last     <= !r_pad_first && r_len_ok;
                    end
                end
                S_HASH: begin
                    if (core_sts.done) begin
                        r_len_ok <= 1'b1;
                        if (r_last) begin
                            r_state     <= S_OUT;
                            r_out_valid <= 1'b1;
                            r_widx      <= 3'd0;
                            r_pad_pend  <= 1'b0;
                            r_last      <= 1'b0;
                        end else if (r_pad_pend) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_OUT: begin
                    if (out_take) begin
                        if (r_widx == 3'd7) begin
                            r_out_valid <= 1'b0;
                            r_total     <= 61'd0;
                            r_state     <= S_IDLE;
                        end else begin
                            r_widx <= r_widx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result item
    assign o_valid       = r_out_valid;
    assign o_digest_word = core_h[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == 3'd7);

`ifndef NO_ASSERTIONS
    a_out_in_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT && r_fill == 6'd0))
        else $error("digest offered outside output phase or with bytes pending");
    a_core_busy_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_sts.busy |-> r_state == S_HASH)
        else $error("compression running outside hash state");
    a_hash_from_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_HASH) ##1 (r_state == S_HASH) |-> $past(r_fill) == 6'd63)
        else $error("compression started on a partial block");
`endif

endmodule

FILE: src/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// SHA-256 compression unit: a 16-word schedule window, one round per cycle
// over 64 rounds, then the C_ADD state folds the working words into the
// chaining words.
// ----------------------------------------------------------------------------
module sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sha_pkg::t_core_ctl i_ctl,
    output sha_pkg::t_core_sts o_sts,
    output sha_pkg::t_words    o_h
);
    import sha_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} t_cstate;

    t_cstate           r_state;
    logic [5:0]        r_round;
    logic [15:0][31:0] r_w;      // r_w[0] is the word used by the current round
    t_words            r_v;      // working words a..h in slices 0..7
    t_words            r_h;

    logic [31:0] sig0, sig1, n_w;
    logic [31:0] big0, big1, ch, maj, t1, t2;
    t_words      n_v;

    // Message schedule: next window word
    always_comb begin
        sig0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        sig1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        n_w  = r_w[0] + sig0 + r_w[9] + sig1;
    end

    // One compression round
    always_comb begin
        big1 = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + big1 + ch + sha_k(r_round) + r_w[0];
        big0 = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = big0 + maj;
        n_v[7] = r_v[6];
        n_v[6] = r_v[5];
        n_v[5] = r_v[4];
        n_v[4] = r_v[3] + t1;
        n_v[3] = r_v[2];
        n_v[2] = r_v[1];
        n_v[1] = r_v[0];
        n_v[0] = t1 + t2;
    end

    assign o_sts.busy = (r_state != C_IDLE);
    assign o_sts.done = (r_state == C_ADD);
    assign o_h        = r_h;

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_round <= 6'd0;
            r_h     <= SHA_IV;
        end else begin
            case (r_state)
                C_IDLE: begin
                    if (i_ctl.word_we) begin
                        r_w <= {i_ctl.word, r_w[15:1]};
                    end
                    if (i_ctl.init_h) begin
                        r_h <= SHA_IV;
                    end
                    if (i_ctl.start) begin
                        r_v     <= r_h;
                        r_round <= 6'd0;
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_w     <= {n_w, r_w[15:1]};
                    r_v     <= n_v;
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) begin
                        r_state <= C_ADD;
                    end
                end
                C_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == C_IDLE)
        else $error("compression started while busy");
    a_no_word_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.word_we |-> r_state == C_IDLE)
        else $error("message word written during compression");
    a_round_to_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == C_ROUND && r_round == 6'd63) |=> r_state == C_ADD)
        else $error("last round not followed by chaining update");
`endif

endmodule

FILE: dv/sha256_stream_hasher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher_tb
// Self-checking bench for the byte-serial SHA-256 hasher. A queue of message
// items feeds a bursty driver. Every accepted item runs through a local
// SHA-256 predictor. A monitor compares each digest word, its index and its
// last flag against the oldest predicted word. The receiver stalls in
// patterns, and once holds off for a long stretch.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_tb;
    import sha_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 250;

    localparam logic [0:7][31:0] INIT_H = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // One queued input item; drain marks a pause until all digests are out
    typedef struct {
        logic [1:0] mode;
        logic [7:0] data;
        bit         drain;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } t_digest_word;

    // DUT ports
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode = MODE_APPEND;
    logic [7:0]  i_message_byte = 8'h00;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Predictor state
    logic [31:0] hash_h [8];
    logic [7:0]  blk_bytes [64];
    int unsigned blk_fill;
    logic [60:0] msg_bytes;

    t_msg_item    msg_item_q [$];
    t_digest_word digest_q [$];
    t_msg_item    cur_item = '{mode: MODE_APPEND, data: 8'h00, drain: 1'b0};

    // Driver, monitor and receiver bookkeeping
    bit          in_taken = 1'b0;
    bit          offering = 1'b0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    bit          hold_used = 1'b0;
    bit          stall_next = 1'b0;
    int unsigned rx_style = 0;
    int unsigned rx_style_left = 0;
    bit          rx_phase = 1'b0;

    int unsigned cycle_count = 0;
    int unsigned errors = 0;
    int unsigned words_checked = 0;
    int unsigned digests_done = 0;
    int unsigned spill_blocks = 0;
    int unsigned ignored_items = 0;
    int unsigned stim_items = 0;

    sha256_stream_hasher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_message_byte (i_message_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        logic [63:0] dbl;
        dbl = {x, x} >> n;
        return dbl[31:0];
    endfunction

    task automatic predictor_clear();
        int unsigned i;
        for (i = 0; i < 8; i++) hash_h[i] = INIT_H[i];
        for (i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        blk_fill = 0;
        msg_bytes = '0;
    endtask

    // 64 rounds over the current block, folded into the chaining words
    task automatic sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        int unsigned i;
        for (i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3];
        e = hash_h[4]; f = hash_h[5]; g = hash_h[6]; h = hash_h[7];
        for (i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_K[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    // Predict the digest words that one accepted item causes
    task automatic hash_item(input logic [1:0] mode, input logic [7:0] data);
        logic [63:0]  bit_len;
        t_digest_word dw;
        int unsigned  i;
        if (mode == MODE_UNUSED) return;
        if (mode != MODE_FINISH) begin
            blk_bytes[blk_fill & 63] = data;
            blk_fill = (blk_fill + 1) & 127;
            msg_bytes = msg_bytes + 1'b1;
            if (blk_fill >= 64) begin
                sha_compress();
                blk_fill = 0;
            end
        end
        if (mode == MODE_APPEND) return;

        // Padding: marker, zeros, then the bit length big-endian
        bit_len = {msg_bytes, 3'b000};
        blk_bytes[blk_fill & 63] = PAD_MARKER;
        blk_fill = (blk_fill + 1) & 127;
        if (blk_fill > LEN_OFFSET) begin
            for (i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
            sha_compress();
            blk_fill = 0;
            spill_blocks++;
        end
        for (i = blk_fill; i < LEN_OFFSET; i++) blk_bytes[i] = 8'h00;
        for (i = 0; i < 8; i++) blk_bytes[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
        sha_compress();

        for (i = 0; i < 8; i++) begin
            dw.word = hash_h[i];
            dw.index = 3'(i);
            dw.last = (i == 7);
            digest_q.push_back(dw);
        end
        digests_done++;
        predictor_clear();
    endtask

    task automatic push_item(input logic [1:0] mode, input logic [7:0] data);
        msg_item_q.push_back('{mode: mode, data: data, drain: 1'b0});
        if (mode == MODE_UNUSED) ignored_items++;
        else stim_items++;
    endtask

    task automatic push_drain();
        msg_item_q.push_back('{mode: MODE_APPEND, data: 8'h00, drain: 1'b1});
    endtask

    // A message of random bytes, finished either on its last byte or by a bare finish
    task automatic push_message(input int unsigned len);
        int unsigned k;
        bit          last_in_byte;
        last_in_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0)
                push_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
            if (last_in_byte && k == len - 1)
                push_item(MODE_APPEND_LAST, 8'($urandom_range(0, 255)));
            else
                push_item(MODE_APPEND, 8'($urandom_range(0, 255)));
        end
        if (!last_in_byte) push_item(MODE_FINISH, 8'($urandom_range(0, 255)));
    endtask

    // Sample side: predict on input accept, check on output accept, watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        in_taken = (i_valid === 1'b1) && (o_stall === 1'b0);
        if (i_rst_n) begin
            if (in_taken) hash_item(i_mode, i_message_byte);
            if (o_valid === 1'b1 && !i_stall) begin
                if (digest_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected digest word %h index %0d last %0d",
                                 o_digest_word, o_word_index, o_last_word);
                end else begin
                    t_digest_word dw;
                    dw = digest_q.pop_front();
                    words_checked++;
                    if (o_digest_word !== dw.word || o_word_index !== dw.index
                        || o_last_word !== dw.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: word %0d exp %h/%0d/%0d got %h/%0d/%0d",
                                     words_checked, dw.word, dw.index, dw.last,
                                     o_digest_word, o_word_index, o_last_word);
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Driver: bursts of items with random gaps, payload held until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (offering && in_taken) offering = 1'b0;
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (msg_item_q.size() > 0) begin
                    if (msg_item_q[0].drain) begin
                        if (digest_q.size() == 0) void'(msg_item_q.pop_front());
                    end else begin
                        cur_item = msg_item_q.pop_front();
                        offering = 1'b1;
                        if (burst_left > 0) burst_left--;
                        if (burst_left == 0) begin
                            burst_left = $urandom_range(1, 40);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
            end
        end
        i_valid <= offering;
        i_mode <= cur_item.mode;
        i_message_byte <= cur_item.data;
    end

    // Receiver: changing stall styles, plus one long hold-off after three digests
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else if (!hold_used && words_checked >= 24) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            stall_next = 1'b1;
        end else begin
            if (rx_style_left == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_style_left = $urandom_range(10, 80);
            end else begin
                rx_style_left--;
            end
            rx_phase = ~rx_phase;
            case (rx_style)
                0: begin
                    stall_next = 1'b0;
                end
                1: begin
                    stall_next = ($urandom_range(0, 3) == 0);
                end
                2: begin
                    stall_next = ($urandom_range(0, 4) < 3);
                end
                default: begin
                    stall_next = rx_phase;
                end
            endcase
        end
        i_stall <= stall_next;
    end

    initial begin
        int unsigned r;
        predictor_clear();

        // Directed: empty message, ignored mode, short known and edge bytes
        push_item(MODE_FINISH, 8'h00);
        push_item(MODE_UNUSED, 8'hFF);
        push_item(MODE_FINISH, 8'hFF);
        push_item(MODE_APPEND, 8'h61);
        push_item(MODE_APPEND, 8'h62);
        push_item(MODE_APPEND_LAST, 8'h63);
        push_item(MODE_APPEND_LAST, 8'hFF);
        push_item(MODE_APPEND_LAST, 8'h00);
        push_item(MODE_APPEND, 8'h00);
        push_item(MODE_UNUSED, 8'h55);
        push_item(MODE_APPEND, 8'hFF);
        push_item(MODE_FINISH, 8'hAA);
        push_item(MODE_UNUSED, 8'h00);
        push_drain();

        // A full block, then 56 pending so the padding spills into an extra block
        push_message(120);
        push_drain();

        // Short messages, some stray items
        while (stim_items < 160) begin
            r = $urandom_range(0, 15);
            if (r == 0)
                push_drain();
            else if (r <= 2)
                push_item(MODE_UNUSED, 8'($urandom_range(0, 255)));
            else
                push_message($urandom_range(0, 12));
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (msg_item_q.size() != 0 || offering) @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run hashed %0d messages (%0d needing a spill block) from %0d items;",
                 digests_done, spill_blocks, stim_items);
        $display("%0d ignored items, %0d digest words checked, %0d mismatches.",
                 ignored_items, words_checked, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
